// ----- sv/tcce_pkg.sv -----
// Shared constants, types and command codes for the text console cursor engine.
package tcce_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROW_COUNT  = 25;
  localparam int CELL_COUNT = COLUMNS * ROW_COUNT;

  localparam int CELL_AW  = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int COL_W    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int ROW_W    = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int CELL_W   = 16;
  localparam int CMD_W    = 2;
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int CURSOR_W = 11;
  localparam int RIDX_W   = 11;
  localparam int CMP_W    = 17;

  localparam int QUEUE_DEPTH = 2;
  localparam int QAW         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  localparam logic [ATTR_W-1:0] RESET_ATTR  = 8'h07;
  localparam logic [CELL_W-1:0] RESET_BLANK = {RESET_ATTR, CH_SPACE};

  typedef logic [2:0] kind_t;

  localparam kind_t K_NOP     = 3'd0;
  localparam kind_t K_PUT     = 3'd1;
  localparam kind_t K_NEWLINE = 3'd2;
  localparam kind_t K_BACK    = 3'd3;
  localparam kind_t K_CLEAR   = 3'd4;
  localparam kind_t K_READ    = 3'd5;

  typedef struct packed {
    kind_t               kind;
    logic [CHAR_W-1:0]   ch;
    logic [CELL_AW-1:0]  addr;
  } op_t;

endpackage

// ----- sv/tcce_ram.sv -----
// Generic single-port RAM with registered read data.
module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                         wdata,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- sv/tcce_front.sv -----
// Front end: accepts commands and classifies them into queue entries.
module tcce_front (
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tcce_pkg::CMD_W-1:0]   in_cmd,
  input  logic [tcce_pkg::CHAR_W-1:0]  in_char_code,
  input  logic [tcce_pkg::RIDX_W-1:0]  in_read_index,
  input  logic                         q_full,
  input  logic                         back_busy,
  output logic                         push,
  output tcce_pkg::op_t                push_op
);

  logic in_range;

  assign in_range = tcce_pkg::CMP_W'(in_read_index) <
                    tcce_pkg::CMP_W'(tcce_pkg::CELL_COUNT);
  assign in_stall = q_full | back_busy;
  assign push     = in_valid & ~in_stall;

  always_comb begin
    push_op.ch   = in_char_code;
    push_op.addr = tcce_pkg::CELL_AW'(in_read_index);
    push_op.kind = tcce_pkg::K_NOP;
    unique case (in_cmd)
      tcce_pkg::CMD_PUT: begin
        if (in_char_code == tcce_pkg::CH_NEWLINE || in_char_code == tcce_pkg::CH_RETURN) begin
          push_op.kind = tcce_pkg::K_NEWLINE;
        end else if (in_char_code == tcce_pkg::CH_BACKSPACE) begin
          push_op.kind = tcce_pkg::K_BACK;
        end else begin
          push_op.kind = tcce_pkg::K_PUT;
        end
      end
      tcce_pkg::CMD_CLEAR: push_op.kind = tcce_pkg::K_CLEAR;
      tcce_pkg::CMD_READ:  push_op.kind = in_range ? tcce_pkg::K_READ : tcce_pkg::K_NOP;
      default:             push_op.kind = tcce_pkg::K_NOP;
    endcase
  end

endmodule

// ----- sv/tcce_queue.sv -----
// Short command queue between front end and back end.
module tcce_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tcce_pkg::op_t push_op,
  input  logic          pop,
  output tcce_pkg::op_t head_op,
  output logic          empty,
  output logic          full
);

  tcce_pkg::op_t               entry_r [tcce_pkg::QUEUE_DEPTH];
  logic [tcce_pkg::QAW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [tcce_pkg::QAW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [tcce_pkg::QAW:0]      count_r, count_nxt;

  assign empty   = (count_r == '0);
  assign full    = (count_r == (tcce_pkg::QAW + 1)'(tcce_pkg::QUEUE_DEPTH));
  assign head_op = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == tcce_pkg::QAW'(tcce_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + tcce_pkg::QAW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == tcce_pkg::QAW'(tcce_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + tcce_pkg::QAW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + (tcce_pkg::QAW + 1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (tcce_pkg::QAW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (full && !pop) |-> !push) else $error("push into full queue");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + (tcce_pkg::QAW + 1)'(1))
    else $error("queue count did not advance on push");

endmodule

// ----- sv/tcce_back.sv -----
// Back end: cursor tracking, cell store access, screen blanking and result register.
module tcce_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic [tcce_pkg::ATTR_W-1:0]    cfg_text_attribute,
  input  tcce_pkg::op_t                  q_op,
  input  logic                           q_empty,
  output logic                           pop,
  output logic                           busy,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tcce_pkg::CURSOR_W-1:0]  out_cursor_position,
  output logic [tcce_pkg::CELL_W-1:0]    out_cell_value,
  output logic                           out_wrapped_clear
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;

  localparam logic [tcce_pkg::COL_W-1:0]   COL_LAST   = tcce_pkg::COL_W'(tcce_pkg::COLUMNS - 1);
  localparam logic [tcce_pkg::ROW_W-1:0]   ROW_LAST   = tcce_pkg::ROW_W'(tcce_pkg::ROW_COUNT - 1);
  localparam logic [tcce_pkg::CELL_AW-1:0] CELL_LAST  = tcce_pkg::CELL_AW'(tcce_pkg::CELL_COUNT - 1);
  localparam logic [tcce_pkg::CELL_AW-1:0] ROW_STRIDE = tcce_pkg::CELL_AW'(tcce_pkg::COLUMNS);

  logic [1:0]                       state_r, state_nxt;
  logic [tcce_pkg::CELL_AW-1:0]     cursor_r, cursor_nxt;
  logic [tcce_pkg::COL_W-1:0]       col_r, col_nxt;
  logic [tcce_pkg::ROW_W-1:0]       row_r, row_nxt;
  logic [tcce_pkg::CELL_AW-1:0]     sweep_r, sweep_nxt;
  logic [tcce_pkg::CELL_W-1:0]      blank_r, blank_nxt;
  logic [tcce_pkg::ATTR_W-1:0]      attr_r;
  logic                             out_valid_r, out_valid_nxt;
  logic [tcce_pkg::CURSOR_W-1:0]    out_cursor_r, out_cursor_nxt;
  logic [tcce_pkg::CELL_W-1:0]      out_cell_r, out_cell_nxt;
  logic                             out_wrap_r, out_wrap_nxt;

  logic                             ram_we;
  logic [tcce_pkg::CELL_AW-1:0]     ram_addr;
  logic [tcce_pkg::CELL_W-1:0]      ram_wdata;
  logic [tcce_pkg::CELL_W-1:0]      ram_rdata;
  logic [tcce_pkg::CELL_W-1:0]      blank_now;
  logic                             out_free;
  logic                             wrap;
  logic                             emit;

  tcce_ram #(
    .WIDTH (tcce_pkg::CELL_W),
    .DEPTH (tcce_pkg::CELL_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign blank_now           = {attr_r, tcce_pkg::CH_SPACE};
  assign out_free            = ~out_valid_r | ~out_stall;
  assign busy                = (state_r == ST_SWEEP);
  assign out_valid           = out_valid_r;
  assign out_cursor_position = out_cursor_r;
  assign out_cell_value      = out_cell_r;
  assign out_wrapped_clear   = out_wrap_r;

  always_comb begin
    state_nxt      = state_r;
    cursor_nxt     = cursor_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    sweep_nxt      = sweep_r;
    blank_nxt      = blank_r;
    out_valid_nxt  = out_valid_r & out_stall;
    out_cursor_nxt = out_cursor_r;
    out_cell_nxt   = out_cell_r;
    out_wrap_nxt   = out_wrap_r;
    pop            = 1'b0;
    ram_we         = 1'b0;
    ram_addr       = cursor_r;
    ram_wdata      = {attr_r, q_op.ch};
    wrap           = 1'b0;
    emit           = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty && out_free) begin
          pop  = 1'b1;
          emit = 1'b1;
          unique case (q_op.kind)
            tcce_pkg::K_PUT: begin
              ram_we = 1'b1;
              if (col_r == COL_LAST) begin
                if (row_r == ROW_LAST) begin
                  wrap = 1'b1;
                end else begin
                  col_nxt    = '0;
                  row_nxt    = row_r + tcce_pkg::ROW_W'(1);
                  cursor_nxt = cursor_r + tcce_pkg::CELL_AW'(1);
                end
              end else begin
                col_nxt    = col_r + tcce_pkg::COL_W'(1);
                cursor_nxt = cursor_r + tcce_pkg::CELL_AW'(1);
              end
            end
            tcce_pkg::K_NEWLINE: begin
              if (row_r == ROW_LAST) begin
                wrap = 1'b1;
              end else begin
                col_nxt    = '0;
                row_nxt    = row_r + tcce_pkg::ROW_W'(1);
                cursor_nxt = cursor_r - tcce_pkg::CELL_AW'(col_r) + ROW_STRIDE;
              end
            end
            tcce_pkg::K_BACK: begin
              if (cursor_r != '0) begin
                ram_we     = 1'b1;
                ram_addr   = cursor_r - tcce_pkg::CELL_AW'(1);
                ram_wdata  = blank_now;
                cursor_nxt = cursor_r - tcce_pkg::CELL_AW'(1);
                if (col_r == '0) begin
                  col_nxt = COL_LAST;
                  row_nxt = row_r - tcce_pkg::ROW_W'(1);
                end else begin
                  col_nxt = col_r - tcce_pkg::COL_W'(1);
                end
              end
            end
            tcce_pkg::K_CLEAR: begin
              cursor_nxt = '0;
              col_nxt    = '0;
              row_nxt    = '0;
              sweep_nxt  = '0;
              blank_nxt  = blank_now;
              state_nxt  = ST_SWEEP;
            end
            tcce_pkg::K_READ: begin
              ram_addr  = q_op.addr;
              emit      = 1'b0;
              state_nxt = ST_READ;
            end
            default: begin
            end
          endcase
          if (wrap) begin
            cursor_nxt = '0;
            col_nxt    = '0;
            row_nxt    = '0;
            sweep_nxt  = '0;
            blank_nxt  = blank_now;
            state_nxt  = ST_SWEEP;
          end
          if (emit) begin
            out_valid_nxt  = 1'b1;
            out_cursor_nxt = tcce_pkg::CURSOR_W'(cursor_nxt);
            out_cell_nxt   = '0;
            out_wrap_nxt   = wrap;
          end
        end
      end
      ST_READ: begin
        out_valid_nxt  = 1'b1;
        out_cursor_nxt = tcce_pkg::CURSOR_W'(cursor_r);
        out_cell_nxt   = ram_rdata;
        out_wrap_nxt   = 1'b0;
        state_nxt      = ST_IDLE;
      end
      ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_addr  = sweep_r;
        ram_wdata = blank_r;
        if (sweep_r == CELL_LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          sweep_nxt = sweep_r + tcce_pkg::CELL_AW'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      cursor_r    <= '0;
      col_r       <= '0;
      row_r       <= '0;
      sweep_r     <= '0;
      blank_r     <= tcce_pkg::RESET_BLANK;
      attr_r      <= tcce_pkg::RESET_ATTR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      sweep_r     <= sweep_nxt;
      blank_r     <= blank_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        attr_r <= cfg_text_attribute;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_cursor_r <= out_cursor_nxt;
    out_cell_r   <= out_cell_nxt;
    out_wrap_r   <= out_wrap_nxt;
  end

  a_sweep_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP) |-> !pop) else $error("command taken during blanking");
  a_read_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> out_valid_r) else $error("read result not produced");
  a_wrap_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && wrap) |=> (state_r == ST_SWEEP && cursor_r == '0))
    else $error("overflow did not start blanking");
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= CELL_LAST) else $error("cursor beyond cell count");
  a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> !out_valid_r) else $error("read result overwrites pending result");

endmodule

// ----- sv/text_console_cursor_engine.sv -----
// A put, clear, unused or out-of-range read shows its result after the command queue and the result
// register; an in-range read also passes the cell store read (ST_READ) before the result register.
// Takes one command per cycle while idle and out_stall is low; a read holds the back end in ST_READ.
// A clear or an overflow blanks the store one cell a cycle, over all 2000 cells, with input stalled.
// Reset (rst_n low, synchronous) homes the cursor, sets attribute 7 and runs a blanking pass over all
// 2000 cells to 0x0720 during which in_stall stays high; configuration is taken throughout.
module text_console_cursor_engine (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [tcce_pkg::CMD_W-1:0]     in_cmd,
  input  logic [tcce_pkg::CHAR_W-1:0]    in_char_code,
  input  logic [tcce_pkg::RIDX_W-1:0]    in_read_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tcce_pkg::CURSOR_W-1:0]  out_cursor_position,
  output logic [tcce_pkg::CELL_W-1:0]    out_cell_value,
  output logic                           out_wrapped_clear,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tcce_pkg::ATTR_W-1:0]    cfg_text_attribute
);

  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_empty;
  logic          back_busy;
  tcce_pkg::op_t push_op;
  tcce_pkg::op_t head_op;

  assign cfg_ready = 1'b1;

  tcce_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_char_code  (in_char_code),
    .in_read_index (in_read_index),
    .q_full        (q_full),
    .back_busy     (back_busy),
    .push          (push),
    .push_op       (push_op)
  );

  tcce_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head_op (head_op),
    .empty   (q_empty),
    .full    (q_full)
  );

  tcce_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_text_attribute  (cfg_text_attribute),
    .q_op                (head_op),
    .q_empty             (q_empty),
    .pop                 (pop),
    .busy                (back_busy),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_cursor_position (out_cursor_position),
    .out_cell_value      (out_cell_value),
    .out_wrapped_clear   (out_wrapped_clear)
  );

endmodule
